### hw/rtl/gfcc_pkg.sv
// package for the footprint collision check unit
// holds request and result types, grid sizes, status and register codes
// no dependencies
`default_nettype none

package gfcc_pkg;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int GRID_AW   = $clog2(GRID_COLS * GRID_ROWS);
    localparam int GRID_CW   = $clog2(GRID_COLS);
    localparam int GRID_RW   = $clog2(GRID_ROWS);
    localparam int IDX_W     = 13;

    localparam int COORD_W   = 42;
    localparam int FRAC_W    = 16;
    localparam int CELL_W    = COORD_W - FRAC_W - 1;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_UNKNOWN  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_ERROR    = 2'd3;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic signed [7:0] COST_UNKNOWN    = -8'sd1;
    localparam logic signed [7:0] COST_FREE_LIMIT = 8'sd50;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_MAP_W    = 3'd0;
    localparam logic [2:0] REG_MAP_H    = 3'd1;
    localparam logic [2:0] REG_ORIGIN_X = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd3;
    localparam logic [2:0] REG_CPU      = 3'd4;
    localparam logic [2:0] REG_BOX_X    = 3'd5;
    localparam logic [2:0] REG_BOX_Y    = 3'd6;

    typedef struct packed {
        logic              mode;
        logic signed [23:0] x_pos;
        logic signed [23:0] y_pos;
        logic [7:0]        cell_col;
        logic [7:0]        cell_row;
        logic signed [7:0] cell_cost;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] centre_cost;
    } t_res_item;

endpackage

`default_nettype wire

### hw/rtl/grid_footprint_collision_check_unit.sv
// top level of the footprint collision check unit: grid memory, query sequencer,
// apb register block
// depends on gfcc_pkg
`default_nettype none

// channel  | dir | handshake                 | payload
// in       | in  | i_in_valid / o_in_ready   | i_in  (t_in_item)
// res      | out | o_res_valid / i_res_ready | o_res (t_res_item)
// cfg      | in  | psel penable pwrite pready| paddr pwdata prdata
//
// requests are taken only in idle; a query steps through a multiply, a centre
// read and check, and a sweep of up to (nx+1)*(ny+1) box cells, nx and ny being
// the box sizes' whole parts; the one grid read port gives one box cell per cycle
// reset is synchronous active low and clears control and config registers only;
// the grid is not cleared
// a finished result waits in the output register while new requests are taken

module grid_footprint_collision_check_unit
    import gfcc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output t_res_item              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CRD  = 3'd2;
    localparam logic [2:0] S_CEV  = 3'd3;
    localparam logic [2:0] S_BOX  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;

    // config registers
    logic [8:0]         r_map_w, r_map_h;
    logic signed [23:0] r_org_x, r_org_y;
    logic [15:0]        r_cpu, r_box_x, r_box_y;

    // query datapath
    logic signed [23:0]        r_qx, r_qy;
    logic signed [COORD_W-1:0] r_px, r_py, r_y0;
    logic [7:0]                r_i, r_j;
    logic                      r_iss_done;
    logic                      r_rd_vld, r_rd_ok, r_rd_last;
    logic [1:0]                r_cstat, r_res_stat;
    logic signed [7:0]         r_ccost;
    logic                      r_out_vld;
    t_res_item                 r_out;

    // grid memory
    logic signed [7:0] mem [GRID_COLS*GRID_ROWS];
    logic signed [7:0] r_rdata;

    logic                      cfg_we;
    logic [2:0]                cfg_idx;
    logic                      in_acc;
    logic                      mem_we, mem_re;
    logic [GRID_AW-1:0]        wr_addr, rd_addr;
    logic [CELL_W-1:0]         p_col, p_row;
    logic                      probe_ok;
    logic signed [24:0]        dx, dy;
    logic signed [16:0]        cpu_s;
    logic signed [COORD_W-1:0] half_x, half_y, one_cell;
    logic [7:0]                nx, ny;
    logic                      iss_last;
    logic [1:0]                c_stat, s_stat, hit_stat;
    logic                      hit, box_end;

    function automatic logic [1:0] classify(input logic ok, input logic signed [7:0] c);
        logic [1:0] s;
        if (!ok) begin
            s = ST_ERROR;
        end else if (c == COST_UNKNOWN) begin
            s = ST_UNKNOWN;
        end else if (c >= 8'sd0 && c < COST_FREE_LIMIT) begin
            s = ST_FREE;
        end else begin
            s = ST_OCCUPIED;
        end
        return s;
    endfunction

    // apb
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_MAP_W:    prdata = 32'(r_map_w);
            REG_MAP_H:    prdata = 32'(r_map_h);
            REG_ORIGIN_X: prdata = 32'({r_org_x});
            REG_ORIGIN_Y: prdata = 32'({r_org_y});
            REG_CPU:      prdata = 32'(r_cpu);
            REG_BOX_X:    prdata = 32'(r_box_x);
            REG_BOX_Y:    prdata = 32'(r_box_y);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 9'd256;
            r_map_h <= 9'd256;
            r_org_x <= 24'sd0;
            r_org_y <= 24'sd0;
            r_cpu   <= 16'd256;
            r_box_x <= 16'd0;
            r_box_y <= 16'd0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MAP_W:    r_map_w <= pwdata[8:0];
                REG_MAP_H:    r_map_h <= pwdata[8:0];
                REG_ORIGIN_X: r_org_x <= $signed(pwdata[23:0]);
                REG_ORIGIN_Y: r_org_y <= $signed(pwdata[23:0]);
                REG_CPU:      r_cpu   <= pwdata[15:0];
                REG_BOX_X:    r_box_x <= pwdata[15:0];
                REG_BOX_Y:    r_box_y <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // request side
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign mem_we  = in_acc && (i_in.mode == MODE_WRITE)
                     && (IDX_W'(i_in.cell_col) < IDX_W'(GRID_COLS))
                     && (IDX_W'(i_in.cell_row) < IDX_W'(GRID_ROWS));
    assign wr_addr = GRID_AW'(GRID_AW'(i_in.cell_row) * GRID_AW'(GRID_COLS)
                              + GRID_AW'(i_in.cell_col));

    // probe of one cell at (r_px, r_py)
    assign p_col    = r_px[COORD_W-2:FRAC_W];
    assign p_row    = r_py[COORD_W-2:FRAC_W];
    assign probe_ok = !r_px[COORD_W-1] && !r_py[COORD_W-1]
                      && (p_col < CELL_W'(r_map_w)) && (p_col < CELL_W'(GRID_COLS))
                      && (p_row < CELL_W'(r_map_h)) && (p_row < CELL_W'(GRID_ROWS));
    assign rd_addr  = GRID_AW'(GRID_AW'(p_row[GRID_RW-1:0]) * GRID_AW'(GRID_COLS)
                               + GRID_AW'(p_col[GRID_CW-1:0]));
    assign mem_re   = probe_ok && ((r_state == S_CRD)
                                   || ((r_state == S_BOX) && !r_iss_done));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_in.cell_cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // arithmetic
    assign dx       = 25'(r_qx) - 25'(r_org_x);
    assign dy       = 25'(r_qy) - 25'(r_org_y);
    assign cpu_s    = $signed({1'b0, r_cpu});
    assign half_x   = $signed(COORD_W'({r_box_x, 7'b0}));
    assign half_y   = $signed(COORD_W'({r_box_y, 7'b0}));
    assign one_cell = $signed(COORD_W'(1) << FRAC_W);
    assign nx       = r_box_x[15:8];
    assign ny       = r_box_y[15:8];
    assign iss_last = (r_i == nx) && (r_j == ny);

    // evaluation
    assign c_stat   = classify(r_rd_ok, r_rdata);
    assign s_stat   = c_stat;
    assign hit      = (r_cstat == ST_FREE) ? (s_stat != ST_FREE)
                                           : ((s_stat == ST_OCCUPIED) || (s_stat == ST_ERROR));
    assign hit_stat = (r_cstat == ST_FREE) ? ST_ERROR : s_stat;
    assign box_end  = r_rd_vld && (hit || r_rd_last);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.mode == MODE_QUERY)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_CRD;
            S_CRD: n_state = S_CEV;
            S_CEV: begin
                if ((c_stat == ST_OCCUPIED) || (c_stat == ST_ERROR)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_BOX;
                end
            end
            S_BOX: begin
                if (box_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_iss_done <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_vld || i_res_ready)) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_state == S_CEV) begin
                r_rd_vld   <= 1'b0;
                r_iss_done <= 1'b0;
            end else if (r_state == S_BOX) begin
                r_rd_vld <= !r_iss_done;
                if (!r_iss_done && iss_last) begin
                    r_iss_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qx <= i_in.x_pos;
                r_qy <= i_in.y_pos;
            end
            S_MUL: begin
                r_px <= COORD_W'(dx * cpu_s);
                r_py <= COORD_W'(dy * cpu_s);
            end
            S_CRD: begin
                r_rd_ok <= probe_ok;
                r_px    <= r_px - half_x;
                r_py    <= r_py - half_y;
                r_y0    <= r_py - half_y;
            end
            S_CEV: begin
                r_cstat    <= c_stat;
                r_res_stat <= c_stat;
                r_ccost    <= r_rd_ok ? r_rdata : 8'sd0;
                r_i        <= 8'd0;
                r_j        <= 8'd0;
            end
            S_BOX: begin
                if (!r_iss_done) begin
                    r_rd_ok   <= probe_ok;
                    r_rd_last <= iss_last;
                    if (r_j == ny) begin
                        r_j  <= 8'd0;
                        r_i  <= r_i + 8'd1;
                        r_py <= r_y0;
                        r_px <= r_px + one_cell;
                    end else begin
                        r_j  <= r_j + 8'd1;
                        r_py <= r_py + one_cell;
                    end
                end
                if (r_rd_vld) begin
                    r_res_stat <= hit ? hit_stat : r_cstat;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_res_ready) begin
                    r_out.status      <= r_res_stat;
                    r_out.centre_cost <= r_ccost;
                end
            end
            default: ;
        endcase
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

`default_nettype wire

### verif/grid_footprint_collision_check_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for grid_footprint_collision_check_unit: cell writes, footprint
// queries and register settings, checked against an in-bench occupancy grid predictor
// depends on gfcc_pkg and grid_footprint_collision_check_unit

module grid_footprint_collision_check_unit_tb;
    import gfcc_pkg::*;

    localparam int     TOTAL_REQUESTS = 1650;
    localparam int     SETTLE_CYCLES  = 32;
    localparam int     WATCHDOG_LIMIT = 300000;
    localparam longint CELL_STEP      = longint'(1) << FRAC_W;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in        = '0;
    logic              i_res_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic              o_in_ready;
    logic              o_res_valid;
    t_res_item         o_res;
    logic [31:0]       prdata;
    logic              pready;

    logic [8:0]         cfg_map_w = 9'd256;
    logic [8:0]         cfg_map_h = 9'd256;
    logic signed [23:0] cfg_org_x = '0;
    logic signed [23:0] cfg_org_y = '0;
    logic [15:0]        cfg_scale = 16'd256;
    logic [15:0]        cfg_box_x = '0;
    logic [15:0]        cfg_box_y = '0;

    logic signed [7:0] grid_cost   [GRID_COLS*GRID_ROWS];
    bit                grid_loaded [GRID_COLS*GRID_ROWS];
    t_res_item         pending_results[$];

    int fail_count    = 0;
    int requests_sent = 0;
    int res_hold      = 0;
    int quiet_cycles  = 0;
    bit src_burst     = 1'b0;
    bit sink_burst    = 1'b0;

    grid_footprint_collision_check_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap(input bit burst);
        if (burst || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic signed [7:0] draw_cost();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 8'($urandom_range(0, 49));
        end
        if (pick < 70) begin
            return COST_UNKNOWN;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [1:0] classify_cell(input longint cx, input longint cy,
                                                 output logic signed [7:0] cost,
                                                 output int addr);
        longint col, row;
        cost = '0;
        addr = -1;
        if (cx < 0 || cy < 0) begin
            return ST_ERROR;
        end
        col = cx >>> FRAC_W;
        row = cy >>> FRAC_W;
        if (col >= longint'(cfg_map_w) || col >= GRID_COLS ||
            row >= longint'(cfg_map_h) || row >= GRID_ROWS) begin
            return ST_ERROR;
        end
        addr = int'(row * GRID_COLS + col);
        cost = grid_cost[addr];
        if (cost == COST_UNKNOWN) begin
            return ST_UNKNOWN;
        end
        if (cost >= 0 && cost < COST_FREE_LIMIT) begin
            return ST_FREE;
        end
        return ST_OCCUPIED;
    endfunction

    // returns the first never-written cell the query would read (centre, then sweep), or -1
    function automatic int predict_footprint(input t_in_item req, output t_res_item res);
        longint            cx, cy, x0, y0;
        int                nx, ny, i, j, addr;
        logic [1:0]        centre, cls;
        logic signed [7:0] cost, unused_cost;
        cx = (longint'($signed(req.x_pos)) - longint'(cfg_org_x)) * longint'(cfg_scale);
        cy = (longint'($signed(req.y_pos)) - longint'(cfg_org_y)) * longint'(cfg_scale);
        x0 = cx - (longint'(cfg_box_x) << 7);
        y0 = cy - (longint'(cfg_box_y) << 7);
        nx = int'(cfg_box_x >> 8);
        ny = int'(cfg_box_y >> 8);
        centre = classify_cell(cx, cy, cost, addr);
        res.status      = centre;
        res.centre_cost = cost;
        if (addr >= 0 && !grid_loaded[addr]) begin
            return addr;
        end
        if (centre == ST_OCCUPIED || centre == ST_ERROR) begin
            return -1;
        end
        for (i = 0; i <= nx; i++) begin
            for (j = 0; j <= ny; j++) begin
                cls = classify_cell(x0 + longint'(i) * CELL_STEP, y0 + longint'(j) * CELL_STEP,
                                    unused_cost, addr);
                if (addr >= 0 && !grid_loaded[addr]) begin
                    return addr;
                end
                if (centre == ST_FREE) begin
                    if (cls != ST_FREE) begin
                        res.status = ST_ERROR;
                        return -1;
                    end
                end else if (cls == ST_OCCUPIED || cls == ST_ERROR) begin
                    res.status = cls;
                    return -1;
                end
            end
        end
        return -1;
    endfunction

    function automatic logic signed [23:0] aim_axis(input logic signed [23:0] org,
                                                    input logic [8:0] span);
        longint reach;
        int     off;
        if (cfg_scale == 0 || $urandom_range(0, 4) == 0) begin
            return 24'($urandom);
        end
        reach = ((longint'(span) + 2) << FRAC_W) / longint'(cfg_scale) + 1;
        if (reach > (longint'(1) << 23)) begin
            reach = longint'(1) << 23;
        end
        off = $urandom_range(0, int'(reach)) - int'(reach / 16) - 1;
        return org + 24'(off);
    endfunction

    function automatic logic [8:0] pick_map_dim();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'($urandom_range(1, 256));
            default: return 9'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [15:0] pick_box();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 6 * 256 + 255));
        endcase
    endfunction

    task automatic send_request(input t_in_item req);
        int        gap;
        t_res_item want;
        gap = draw_gap(src_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        requests_sent++;
        if (req.mode == MODE_WRITE) begin
            grid_cost[int'(req.cell_row) * GRID_COLS + int'(req.cell_col)]   = req.cell_cost;
            grid_loaded[int'(req.cell_row) * GRID_COLS + int'(req.cell_col)] = 1'b1;
        end else begin
            void'(predict_footprint(req, want));
            pending_results.push_back(want);
        end
    endtask

    task automatic load_cell(input int col, input int row, input logic signed [7:0] cost);
        t_in_item    req;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        req = raw[$bits(t_in_item)-1:0];
        req.mode      = MODE_WRITE;
        req.cell_col  = 8'(col);
        req.cell_row  = 8'(row);
        req.cell_cost = cost;
        send_request(req);
    endtask

    // cells the sweep would read are written first, so no query touches an unwritten cell
    task automatic run_query(input logic signed [23:0] xp, input logic signed [23:0] yp);
        t_in_item    req;
        t_res_item   res;
        logic [95:0] raw;
        int          hole;
        raw = {$urandom, $urandom, $urandom};
        req = raw[$bits(t_in_item)-1:0];
        req.mode  = MODE_QUERY;
        req.x_pos = xp;
        req.y_pos = yp;
        hole = predict_footprint(req, res);
        while (hole >= 0) begin
            load_cell(hole % GRID_COLS, hole / GRID_COLS, draw_cost());
            hole = predict_footprint(req, res);
        end
        send_request(req);
    endtask

    task automatic aimed_queries(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            run_query(aim_axis(cfg_org_x, cfg_map_w), aim_axis(cfg_org_y, cfg_map_h));
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_MAP_W:    cfg_map_w = val[8:0];
            REG_MAP_H:    cfg_map_h = val[8:0];
            REG_ORIGIN_X: cfg_org_x = val[23:0];
            REG_ORIGIN_Y: cfg_org_y = val[23:0];
            REG_CPU:      cfg_scale = val[15:0];
            REG_BOX_X:    cfg_box_x = val[15:0];
            REG_BOX_Y:    cfg_box_y = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [8:0] mw, input logic [8:0] mh,
                               input logic signed [23:0] ox, input logic signed [23:0] oy,
                               input logic [15:0] scale, input logic [15:0] bx,
                               input logic [15:0] by);
        settle();
        write_reg(REG_MAP_W, 32'(mw));
        write_reg(REG_MAP_H, 32'(mh));
        write_reg(REG_ORIGIN_X, 32'(ox));
        write_reg(REG_ORIGIN_Y, 32'(oy));
        write_reg(REG_CPU, 32'(scale));
        write_reg(REG_BOX_X, 32'(bx));
        write_reg(REG_BOX_Y, 32'(by));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_cell_classes();
        logic signed [7:0] costs [8];
        int                k;
        costs = '{8'sd0, 8'sd49, 8'sd50, -8'sd1, 8'sd100, 8'sd127, -8'sd128, -8'sd2};
        for (k = 0; k < 8; k++) begin
            load_cell(k, 0, costs[k]);
            run_query(24'(k * 256 + k * 31), 24'(k * 3));
        end
        run_query(-24'sd1, 24'sd0);
        run_query(24'sd0, 24'sh800000);
        load_cell(255, 255, 8'sd10);
        run_query(24'sh00FFFF, 24'sh00FFFF);
        run_query(24'sh010000, 24'sd5);
        run_query(24'sh7FFFFF, 24'sh7FFFFF);
    endtask

    task automatic test_footprint_sweeps();
        int r, c, k;
        apply_setup(9'd8, 9'd8, 24'sd0, 24'sd0, 16'd256, 16'd640, 16'd384);
        for (r = 0; r < 8; r++) begin
            for (c = 0; c < 8; c++) begin
                load_cell(c, r, 8'($urandom_range(0, 49)));
            end
        end
        aimed_queries(12);
        for (k = 0; k < 8; k++) begin
            load_cell($urandom_range(0, 7), $urandom_range(0, 7), draw_cost());
        end
        aimed_queries(16);
    endtask

    task automatic test_config_corners();
        int k;
        apply_setup(9'd0, 9'd0, 24'sd0, 24'sd0, 16'd256, 16'd0, 16'd0);
        aimed_queries(3);
        apply_setup(9'd511, 9'd511, 24'sd0, 24'sd0, 16'd256, 16'd0, 16'd0);
        for (k = 0; k < 4; k++) begin
            run_query(24'($urandom_range(250 * 256, 262 * 256 - 1)),
                      24'($urandom_range(250 * 256, 262 * 256 - 1)));
        end
        apply_setup(9'd16, 9'd16, 24'sh800000, 24'sh7FFFFF, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < 4; k++) begin
            run_query(24'($urandom), 24'($urandom));
        end
        apply_setup(9'd256, 9'd256, 24'sh7FFFFF, 24'sh800000, 16'hFFFF, 16'd0, 16'd0);
        aimed_queries(4);
        apply_setup(9'd4, 9'd4, 24'sd0, 24'sd0, 16'd256, 16'hFFFF, 16'hFFFF);
        aimed_queries(4);
        apply_setup(9'd1, 9'd256, 24'sd0, 24'sd0, 16'd1, 16'd255, 16'd255);
        aimed_queries(4);
    endtask

    task automatic test_random_traffic();
        int         phase_len, k, span_x, span_y;
        logic [15:0] scale;
        while (requests_sent < TOTAL_REQUESTS) begin
            case ($urandom_range(0, 5))
                0: scale = 16'd256;
                1: scale = 16'd512;
                2: scale = 16'd128;
                3: scale = 16'($urandom_range(1, 65535));
                default: scale = 16'($urandom_range(64, 1024));
            endcase
            apply_setup(pick_map_dim(), pick_map_dim(),
                        ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom),
                        ($urandom_range(0, 3) == 0) ? 24'sd0 : 24'($urandom),
                        scale, pick_box(), pick_box());
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            span_x = (cfg_map_w > 256) ? 256 : int'(cfg_map_w);
            span_y = (cfg_map_h > 256) ? 256 : int'(cfg_map_h);
            phase_len = $urandom_range(40, 160);
            for (k = 0; k < phase_len && requests_sent < TOTAL_REQUESTS; k++) begin
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 4) == 0 || span_x == 0 || span_y == 0) begin
                        load_cell($urandom_range(0, 255), $urandom_range(0, 255), 8'($urandom));
                    end else begin
                        load_cell($urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1),
                                  draw_cost());
                    end
                end else begin
                    aimed_queries(1);
                end
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_res_item want;
        int        next_hold;
        next_hold = res_hold;
        if (!i_rst_n) begin
            next_hold = 0;
        end else if (o_res_valid && i_res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no query waiting: status %0d cost %0d", $time,
                         o_res.status, $signed(o_res.centre_cost));
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             want.status, o_res.status);
                    fail_count++;
                end
                if (o_res.centre_cost !== want.centre_cost) begin
                    $display("%0t: centre cost mismatch, expected %0d, got %0d", $time,
                             $signed(want.centre_cost), $signed(o_res.centre_cost));
                    fail_count++;
                end
            end
            next_hold = draw_gap(sink_burst);
        end else if (res_hold > 0) begin
            next_hold = res_hold - 1;
        end
        res_hold = next_hold;
        i_res_ready <= (next_hold == 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_res_valid && i_res_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("grid_footprint_collision_check_unit test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cell_classes();
        test_footprint_sweeps();
        test_config_corners();
        test_random_traffic();
        settle();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("grid_footprint_collision_check_unit test passed");
        end else begin
            $display("grid_footprint_collision_check_unit test failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/gfcc_pkg.sv
hw/rtl/grid_footprint_collision_check_unit.sv
verif/grid_footprint_collision_check_unit_tb.sv
